[rtl/sacl_pkg.sv]
`default_nettype none

package sacl_pkg;

  // Configuration register widths and indexes.
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 5;
  localparam int unsigned SET_BITS_W    = 3;
  localparam int unsigned OFFSET_BITS_W = 5;
  localparam int unsigned WAYS_USED_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd2;

  // Access kinds carried by one input word.
  localparam int unsigned KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IFETCH = 2'd3;

  // Running statistics counters.
  localparam int unsigned CNT_W = 32;

endpackage

`default_nettype wire

[rtl/set_assoc_cache_lru_sim.sv]
// Channel   Direction  Handshake                 Word
// -------   ---------  ------------------------  -------------------------------------
// access    in         start_i, busy_o           kind_i, address_i
// result    out        res_strobe_o (one cycle)  hit_o, evicted_o, last_o, *_total_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// After reset the tag memory is cleared one set per cycle, every set in turn, with
// busy_o high; configuration writes are taken during that time.
// A load or store reads the set's row synchronously when it is accepted, then does the
// compare, LRU update and write-back in ST_LOOK before the next access can be accepted.
// A modify looks up twice in ST_LOOK; the second uses the row forwarded from the first.
// An instruction fetch does no lookup, leaves busy_o low and gives no result.
// Each result is shown for one cycle on res_strobe_o; the receiver cannot stall it.
`default_nettype none

module set_assoc_cache_lru_sim import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_BITS    = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [KIND_W-1:0]     kind_i,
  input  wire logic [ADDR_BITS-1:0]  address_i,
  output logic                       res_strobe_o,
  output logic                       hit_o,
  output logic                       evicted_o,
  output logic                       last_o,
  output logic      [CNT_W-1:0]      hit_total_o,
  output logic      [CNT_W-1:0]      miss_total_o,
  output logic      [CNT_W-1:0]      eviction_total_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned REC_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned ROW_W  = MAX_WAYS * (1 + ADDR_BITS + REC_W);
  localparam int unsigned SH_W   = 7;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [SET_BITS_W-1:0]    set_bits_q;
  logic [OFFSET_BITS_W-1:0] offset_bits_q;
  logic [WAYS_USED_W-1:0]   ways_used_q;

  logic [SET_W-1:0]     clr_q;
  logic                 second_q;
  logic                 fwd_sel_q;
  logic [SET_W-1:0]     set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic [ROW_W-1:0]     fwd_row_q;

  logic                 strobe_q;
  logic                 hit_q;
  logic                 evict_q;
  logic                 last_q;
  logic [CNT_W-1:0]     hits_q;
  logic [CNT_W-1:0]     misses_q;
  logic [CNT_W-1:0]     evicts_q;

  // Address split.
  logic                 sb_clamp;
  logic [SET_BITS_W-1:0] sb_eff;
  logic [SET_W-1:0]     set_mask;
  logic [ADDR_BITS-1:0] addr_shifted;
  logic [SET_W-1:0]     set_idx;
  logic [SH_W-1:0]      tag_shift;
  logic [ADDR_BITS-1:0] tag_new;
  logic [WAYS_USED_W:0] ways_wide;
  logic [WCNT_W-1:0]    ways_eff;

  logic                 accept;
  logic                 lookup_start;

  // Memory and way logic.
  logic                 rd_en;
  logic [ROW_W-1:0]     rd_row;
  logic                 wr_en;
  logic [SET_W-1:0]     wr_addr;
  logic [ROW_W-1:0]     wr_row;
  logic [ROW_W-1:0]     cur_row;
  logic [ROW_W-1:0]     new_row;

  logic [MAX_WAYS-1:0]                cur_valid;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] cur_tags;
  logic [MAX_WAYS-1:0][REC_W-1:0]     cur_recs;
  logic [MAX_WAYS-1:0]                new_valid;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] new_tags;
  logic [MAX_WAYS-1:0][REC_W-1:0]     new_recs;
  logic                               look_hit;
  logic                               look_evict;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign lookup_start = accept && (kind_i != KIND_IFETCH);

  always_comb begin
    sb_clamp     = ({1'b0, set_bits_q} > (SET_BITS_W + 1)'(MAX_SET_BITS));
    sb_eff       = sb_clamp ? SET_BITS_W'(MAX_SET_BITS) : set_bits_q;
    set_mask     = ~({SET_W{1'b1}} << sb_eff);
    addr_shifted = address_i >> offset_bits_q;
    set_idx      = addr_shifted[SET_W-1:0] & set_mask;
    tag_shift    = SH_W'(offset_bits_q) + SH_W'(sb_eff);
    tag_new      = (tag_shift >= SH_W'(ADDR_BITS)) ? '0 : (address_i >> tag_shift);
    ways_wide    = {1'b0, ways_used_q};
    if (ways_used_q == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (ways_wide > (WAYS_USED_W + 1)'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_wide);
    end
  end

  assign rd_en = lookup_start;

  sacl_ram #(
    .ADDR_W(SET_W),
    .DATA_W(ROW_W)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(set_idx),
    .rd_data_o(rd_row),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_row)
  );

  // The second lookup of a modify sees the row that the first one just wrote.
  assign cur_row = fwd_sel_q ? fwd_row_q : rd_row;
  assign {cur_valid, cur_tags, cur_recs} = cur_row;
  assign new_row = {new_valid, new_tags, new_recs};

  sacl_ways #(
    .MAX_WAYS (MAX_WAYS),
    .ADDR_BITS(ADDR_BITS),
    .REC_W    (REC_W),
    .WCNT_W   (WCNT_W)
  ) u_ways (
    .ways_i (ways_eff),
    .tag_i  (tag_q),
    .valid_i(cur_valid),
    .tags_i (cur_tags),
    .recs_i (cur_recs),
    .hit_o  (look_hit),
    .evict_o(look_evict),
    .valid_o(new_valid),
    .tags_o (new_tags),
    .recs_o (new_recs)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = set_q;
    wr_row  = new_row;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_row  = '0;
        if (clr_q == {SET_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (lookup_start) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        wr_en = 1'b1;
        if (!second_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      second_q      <= 1'b0;
      fwd_sel_q     <= 1'b0;
      strobe_q      <= 1'b0;
      hits_q        <= '0;
      misses_q      <= '0;
      evicts_q      <= '0;
      set_bits_q    <= '0;
      offset_bits_q <= '0;
      ways_used_q   <= WAYS_USED_W'(1);
    end else begin
      state_q  <= state_d;
      strobe_q <= 1'b0;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + SET_W'(1);
      end
      if (lookup_start) begin
        second_q  <= (kind_i == KIND_MODIFY);
        fwd_sel_q <= 1'b0;
      end
      if (state_q == ST_LOOK) begin
        strobe_q  <= 1'b1;
        second_q  <= 1'b0;
        fwd_sel_q <= second_q;
        if (look_hit) begin
          hits_q <= hits_q + CNT_W'(1);
        end else begin
          misses_q <= misses_q + CNT_W'(1);
        end
        if (look_evict) begin
          evicts_q <= evicts_q + CNT_W'(1);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SET_BITS:    set_bits_q    <= cfg_data_i[SET_BITS_W-1:0];
          CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i[OFFSET_BITS_W-1:0];
          CFG_WAYS_USED:   ways_used_q   <= cfg_data_i[WAYS_USED_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_start) begin
      set_q <= set_idx;
      tag_q <= tag_new;
    end
    if (state_q == ST_LOOK) begin
      fwd_row_q <= new_row;
      hit_q     <= look_hit;
      evict_q   <= look_evict;
      last_q    <= !second_q;
    end
  end

  assign res_strobe_o     = strobe_q;
  assign hit_o            = hit_q;
  assign evicted_o        = evict_q;
  assign last_o           = last_q;
  assign hit_total_o      = hits_q;
  assign miss_total_o     = misses_q;
  assign eviction_total_o = evicts_q;

`ifndef NO_ASSERTIONS
  a_strobe_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(state_q == ST_LOOK))
    else $error("result word without a preceding lookup");

  a_one_count_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> ((hit_total_o + miss_total_o) ==
                      CNT_W'($past(hit_total_o + miss_total_o) + CNT_W'(1))))
    else $error("hit and miss totals did not advance by one");

  a_evict_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !(hit_o && evicted_o))
    else $error("eviction reported on a hit");

  a_modify_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !last_o) |=> (res_strobe_o && last_o))
    else $error("first word of a modify not followed by its last word");
`endif

endmodule

`default_nettype wire

[rtl/sacl_ram.sv]
`default_nettype none

module sacl_ram #(
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 288
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/sacl_ways.sv]
`default_nettype none

module sacl_ways import sacl_pkg::*; #(
  parameter int unsigned MAX_WAYS  = 8,
  parameter int unsigned ADDR_BITS = 32,
  parameter int unsigned REC_W     = 3,
  parameter int unsigned WCNT_W    = 4
) (
  input  wire logic [WCNT_W-1:0]                  ways_i,
  input  wire logic [ADDR_BITS-1:0]               tag_i,
  input  wire logic [MAX_WAYS-1:0]                valid_i,
  input  wire logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_i,
  input  wire logic [MAX_WAYS-1:0][REC_W-1:0]     recs_i,
  output logic                                    hit_o,
  output logic                                    evict_o,
  output logic      [MAX_WAYS-1:0]                valid_o,
  output logic      [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_o,
  output logic      [MAX_WAYS-1:0][REC_W-1:0]     recs_o
);

  localparam int unsigned WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] empty;
  logic                full;
  logic [WIDX_W-1:0]   hit_way;
  logic [WIDX_W-1:0]   fill_way;
  logic [WIDX_W-1:0]   victim_way;
  logic [REC_W-1:0]    victim_rec;
  logic [WIDX_W-1:0]   way_sel;
  logic [REC_W-1:0]    sel_age;

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      in_use[j] = (WCNT_W'(j) < ways_i);
      match[j]  = in_use[j] && valid_i[j] && (tags_i[j] == tag_i);
      empty[j]  = in_use[j] && !valid_i[j];
    end
  end

  assign hit_o = |match;
  assign full  = ~|empty;

  // Lowest-numbered matching and lowest-numbered empty way.
  always_comb begin
    hit_way  = '0;
    fill_way = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_way = WIDX_W'(j);
      end
      if (empty[j]) begin
        fill_way = WIDX_W'(j);
      end
    end
  end

  // Oldest way in use; the strict compare keeps the lowest index on ties.
  always_comb begin
    victim_way = '0;
    victim_rec = recs_i[0];
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (in_use[j] && (recs_i[j] > victim_rec)) begin
        victim_way = WIDX_W'(j);
        victim_rec = recs_i[j];
      end
    end
  end

  assign evict_o = !hit_o && full;
  assign way_sel = hit_o ? hit_way : (full ? victim_way : fill_way);
  assign sel_age = valid_i[way_sel] ? recs_i[way_sel] : REC_W'(MAX_WAYS - 1);

  // Ways younger than the touched one age by one; the touched way becomes newest.
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      valid_o[j] = valid_i[j];
      tags_o[j]  = tags_i[j];
      recs_o[j]  = recs_i[j];
      if (WIDX_W'(j) == way_sel) begin
        valid_o[j] = 1'b1;
        tags_o[j]  = tag_i;
        recs_o[j]  = '0;
      end else if (in_use[j] && valid_i[j] && (recs_i[j] < sel_age)) begin
        recs_o[j] = recs_i[j] + REC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
module tb_top;
  import sacl_pkg::*;

  localparam int unsigned MAX_SET_BITS  = 6;
  localparam int unsigned MAX_WAYS      = 8;
  localparam int unsigned ADDR_BITS     = 32;
  localparam int unsigned LINE_COUNT    = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic             last;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } lookup_result_t;

  typedef struct packed {
    logic                  is_write;
    logic [KIND_W-1:0]     kind;
    logic [ADDR_BITS-1:0]  addr;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } trace_op_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic [KIND_W-1:0]     kind_i      = KIND_LOAD;
  logic [ADDR_BITS-1:0]  address_i   = '0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  busy_o;
  logic                  res_strobe_o;
  logic                  hit_o;
  logic                  evicted_o;
  logic                  last_o;
  logic [CNT_W-1:0]      hit_total_o;
  logic [CNT_W-1:0]      miss_total_o;
  logic [CNT_W-1:0]      eviction_total_o;
  logic                  cfg_ready_o;

  set_assoc_cache_lru_sim #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_BITS   (ADDR_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .address_i       (address_i),
    .res_strobe_o    (res_strobe_o),
    .hit_o           (hit_o),
    .evicted_o       (evicted_o),
    .last_o          (last_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o),
    .eviction_total_o(eviction_total_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the tag store and statistics.
  logic                 tag_valid [LINE_COUNT];
  logic [ADDR_BITS-1:0] tag_store [LINE_COUNT];
  logic [2:0]           lru_age   [LINE_COUNT];
  logic [CNT_W-1:0]     hit_tally   = '0;
  logic [CNT_W-1:0]     miss_tally  = '0;
  logic [CNT_W-1:0]     evict_count = '0;
  logic [SET_BITS_W-1:0]    cfg_set_bits    = '0;
  logic [OFFSET_BITS_W-1:0] cfg_offset_bits = '0;
  logic [WAYS_USED_W-1:0]   cfg_ways_used   = 4'd1;

  trace_op_t      trace_ops [$];
  lookup_result_t expected_lookups [$];
  int unsigned    gap_left       = 0;
  int unsigned    burst_left     = 0;
  int unsigned    quiet_cycles   = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count    = 0;

  initial begin
    for (int i = 0; i < LINE_COUNT; i++) begin
      tag_valid[i] = 1'b0;
      tag_store[i] = '0;
      lru_age[i]   = '0;
    end
  end

  function automatic int unsigned eff_set_bits(input logic [SET_BITS_W-1:0] v);
    return (v > MAX_SET_BITS) ? MAX_SET_BITS : v;
  endfunction

  function automatic int unsigned eff_ways(input logic [WAYS_USED_W-1:0] v);
    if (v == 0) return 1;
    return (v > MAX_WAYS) ? MAX_WAYS : v;
  endfunction

  // Way w becomes most recent; valid ways younger than w age by one.
  // An invalid way counts as the oldest possible age.
  function automatic void promote_way(input int unsigned base, input int unsigned ways,
                                      input int unsigned w);
    int unsigned ref_age;
    ref_age = tag_valid[base + w] ? lru_age[base + w] : MAX_WAYS - 1;
    for (int unsigned j = 0; j < ways; j++) begin
      if (j != w && tag_valid[base + j] && lru_age[base + j] < ref_age)
        lru_age[base + j] = lru_age[base + j] + 3'd1;
    end
    lru_age[base + w] = '0;
  endfunction

  function automatic lookup_result_t cache_lookup(input logic [ADDR_BITS-1:0] addr);
    int unsigned    sb, ways, shift, set_idx, base, w, fill, victim;
    logic [ADDR_BITS-1:0] tag;
    logic           hit, full;
    lookup_result_t r;
    sb      = eff_set_bits(cfg_set_bits);
    ways    = eff_ways(cfg_ways_used);
    shift   = sb + cfg_offset_bits;
    set_idx = (addr >> cfg_offset_bits) & ((1 << sb) - 1);
    tag     = (shift >= ADDR_BITS) ? '0 : (addr >> shift);
    base    = set_idx * MAX_WAYS;
    hit     = 1'b0;
    full    = 1'b1;
    w       = 0;
    fill    = 0;
    for (int unsigned j = 0; j < ways; j++) begin
      if (!tag_valid[base + j]) begin
        if (full) fill = j;
        full = 1'b0;
      end else if (!hit && tag_store[base + j] == tag) begin
        hit = 1'b1;
        w   = j;
      end
    end
    r = '0;
    r.hit = hit;
    if (hit) begin
      hit_tally = hit_tally + 1;
      promote_way(base, ways, w);
    end else begin
      miss_tally = miss_tally + 1;
      if (full) begin
        victim = 0;
        for (int unsigned j = 1; j < ways; j++)
          if (lru_age[base + j] > lru_age[base + victim]) victim = j;
        w = victim;
        r.evicted = 1'b1;
        evict_count = evict_count + 1;
      end else begin
        w = fill;
      end
      promote_way(base, ways, w);
      tag_valid[base + w] = 1'b1;
      tag_store[base + w] = tag;
    end
    r.hits      = hit_tally;
    r.misses    = miss_tally;
    r.evictions = evict_count;
    return r;
  endfunction

  function automatic void predict_access(input logic [KIND_W-1:0] kind,
                                         input logic [ADDR_BITS-1:0] addr);
    lookup_result_t r;
    if (kind == KIND_IFETCH) return;
    r = cache_lookup(addr);
    if (kind == KIND_MODIFY) begin
      expected_lookups.push_back(r);
      r = cache_lookup(addr);
    end
    r.last = 1'b1;
    expected_lookups.push_back(r);
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SET_BITS:    cfg_set_bits    = val[SET_BITS_W-1:0];
      CFG_OFFSET_BITS: cfg_offset_bits = val[OFFSET_BITS_W-1:0];
      CFG_WAYS_USED:   cfg_ways_used   = val[WAYS_USED_W-1:0];
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one, and bursts with none at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin : drive_proc
    logic      next_start;
    logic      next_cfg;
    trace_op_t op;
    next_start = start_i;
    next_cfg   = cfg_valid_i;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_write(cfg_index_i, cfg_data_i);
        next_cfg = 1'b0;
      end
      if (start_i && !busy_o) begin
        predict_access(kind_i, address_i);
        next_start   = 1'b0;
        gap_left     = pick_gap();
        quiet_cycles = 0;
      end else if (start_i || expected_lookups.size() != 0) begin
        quiet_cycles = 0;
      end else if (quiet_cycles < SETTLE_CYCLES) begin
        quiet_cycles++;
      end
      if (!next_start && !next_cfg && trace_ops.size() != 0) begin
        if (trace_ops[0].is_write) begin
          // Registers change only once the block has drained.
          if (quiet_cycles >= SETTLE_CYCLES) begin
            op = trace_ops.pop_front();
            cfg_index_i <= op.reg_idx;
            cfg_data_i  <= op.reg_val;
            next_cfg    = 1'b1;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          op = trace_ops.pop_front();
          kind_i     <= op.kind;
          address_i  <= op.addr;
          next_start = 1'b1;
        end
      end
    end
    start_i     <= next_start;
    cfg_valid_i <= next_cfg;
  end

  // Results are sampled mid-cycle, where the strobed word is stable.
  always @(negedge clk_i) begin : check_proc
    lookup_result_t got;
    lookup_result_t want;
    if (rst_ni && res_strobe_o === 1'b1) begin
      got = {hit_o, evicted_o, last_o, hit_total_o, miss_total_o, eviction_total_o};
      if (expected_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: hit=%0b evicted=%0b last=%0b",
                   got.hit, got.evicted, got.last,
                   " hits=%0d misses=%0d evictions=%0d",
                   got.hits, got.misses, got.evictions);
      end else begin
        want = expected_lookups.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch at cycle %0d", cycle_count);
            $display("  expected: hit=%0b evicted=%0b last=%0b",
                     want.hit, want.evicted, want.last,
                     " hits=%0d misses=%0d evictions=%0d",
                     want.hits, want.misses, want.evictions);
            $display("  actual:   hit=%0b evicted=%0b last=%0b",
                     got.hit, got.evicted, got.last,
                     " hits=%0d misses=%0d evictions=%0d",
                     got.hits, got.misses, got.evictions);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_access(input logic [KIND_W-1:0] kind, input logic [ADDR_BITS-1:0] addr);
    trace_op_t op;
    op          = '0;
    op.kind     = kind;
    op.addr     = addr;
    trace_ops.push_back(op);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    trace_op_t op;
    op          = '0;
    op.is_write = 1'b1;
    op.reg_idx  = idx;
    op.reg_val  = val;
    trace_ops.push_back(op);
  endtask

  // One setting of the registers, then accesses that mostly revisit a small working set
  // so that hits, fills and evictions all occur; the rest are fully random addresses.
  task automatic add_random_phase(input logic [CFG_DATA_W-1:0] sb_val,
                                  input logic [CFG_DATA_W-1:0] off_val,
                                  input logic [CFG_DATA_W-1:0] ways_val,
                                  input int unsigned count);
    int unsigned          sb, ways, off, n_tags, n_sets, made, r;
    logic [ADDR_BITS-1:0] tag_pool [12];
    int unsigned          set_pool [4];
    logic [63:0]          a;
    logic [KIND_W-1:0]    kind;
    add_write(CFG_SET_BITS, sb_val);
    add_write(CFG_OFFSET_BITS, off_val);
    add_write(CFG_WAYS_USED, ways_val);
    sb     = eff_set_bits(sb_val[SET_BITS_W-1:0]);
    ways   = eff_ways(ways_val[WAYS_USED_W-1:0]);
    off    = off_val[OFFSET_BITS_W-1:0];
    n_tags = ways + $urandom_range(1, 3);
    n_sets = $urandom_range(1, 4);
    for (int i = 0; i < 12; i++) tag_pool[i] = $urandom;
    for (int i = 0; i < 4; i++) set_pool[i] = $urandom_range(0, (1 << sb) - 1);
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 35) kind = KIND_LOAD;
      else if (r < 65) kind = KIND_STORE;
      else if (r < 85) kind = KIND_MODIFY;
      else kind = KIND_IFETCH;
      if ($urandom_range(0, 99) < 80) begin
        a = ({32'd0, tag_pool[$urandom_range(0, n_tags - 1)]} << (sb + off))
          | (64'(set_pool[$urandom_range(0, n_sets - 1)]) << off)
          | (64'($urandom) & ((64'd1 << off) - 64'd1));
      end else begin
        a = 64'($urandom);
      end
      add_access(kind, a[ADDR_BITS-1:0]);
      made++;
    end
  endtask

  initial begin
    // Reset settings: one set, one way, no offset; every new address after the first evicts.
    add_access(KIND_LOAD,   32'h0000_0000);
    add_access(KIND_LOAD,   32'h0000_0003);
    add_access(KIND_STORE,  32'h0000_0003);
    add_access(KIND_MODIFY, 32'hFFFF_FFFF);
    add_access(KIND_IFETCH, 32'hFFFF_FFFF);
    add_access(KIND_LOAD,   32'hFFFF_FFFF);
    add_access(KIND_IFETCH, 32'h0000_0000);
    add_access(KIND_MODIFY, 32'h8000_0000);

    // Two ways in one set: the least recently used line is the victim.
    add_write(CFG_SET_BITS,    5'd0);
    add_write(CFG_OFFSET_BITS, 5'd4);
    add_write(CFG_WAYS_USED,   5'd2);
    add_access(KIND_LOAD,   32'h0000_0100);
    add_access(KIND_LOAD,   32'h0000_0200);
    add_access(KIND_LOAD,   32'h0000_010F);
    add_access(KIND_LOAD,   32'h0000_0300);
    add_access(KIND_LOAD,   32'h0000_0200);
    add_access(KIND_MODIFY, 32'h0000_030C);

    // Out-of-range values: set bits clamp to the maximum, a zero way count acts as one,
    // and offset plus set bits pass the address width so the tag is zero.
    add_write(CFG_SET_BITS,    5'd15);
    add_write(CFG_OFFSET_BITS, 5'd30);
    add_write(CFG_WAYS_USED,   5'd16);
    add_write(CFG_UNUSED,      5'd21);
    add_access(KIND_LOAD,   32'hC000_0000);
    add_access(KIND_LOAD,   32'hC123_4567);
    add_access(KIND_LOAD,   32'h4000_0000);
    add_access(KIND_STORE,  32'h7FFF_FFFF);
    add_access(KIND_MODIFY, 32'h0000_0000);

    add_random_phase(5'd2,  5'd4,  5'd4,  130);
    add_random_phase(5'd6,  5'd16, 5'd8,  150);
    add_random_phase(5'd1,  5'd0,  5'd2,  110);
    add_random_phase(5'd7,  5'd31, 5'd15, 80);
    add_random_phase(5'd31, 5'd26, 5'd16, 90);
    add_write(CFG_UNUSED, 5'd10);
    add_random_phase(5'd3,  5'd2,  5'd3,  130);
    add_random_phase(5'd0,  5'd0,  5'd8,  120);
    add_random_phase(5'd4,  5'd8,  5'd5,  120);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (trace_ops.size() != 0 || start_i || cfg_valid_i || expected_lookups.size() != 0)
      @(negedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && expected_lookups.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
